// File: hw/rtl/v3a_pkg.sv
// Shared types, operation codes and saturation helper for the 3-vector ALU.
// No dependencies.
`default_nettype none

package v3a_pkg;

    // Operation codes carried on the slave tuser
    typedef enum logic [3:0] {
        FN_EQ     = 4'd0,
        FN_ADD    = 4'd1,
        FN_SUB    = 4'd2,
        FN_SCALE  = 4'd3,
        FN_DIV    = 4'd4,
        FN_NEG    = 4'd5,
        FN_CPROD  = 4'd6,
        FN_LEN    = 4'd7,
        FN_SQLEN  = 4'd8,
        FN_DOT    = 4'd9,
        FN_NORM   = 4'd10,
        FN_CROSS  = 4'd11,
        FN_UCROSS = 4'd12
    } t_func;

    localparam int SQRT_STAGES = 32;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    typedef struct packed {
        logic        ov;
        logic [31:0] val;
    } t_sat;

    // Sidecar that travels beside the square root
    typedef struct packed {
        t_func           func;
        logic [2:0][31:0] vec;
        logic [31:0]     sout;
        logic [31:0]     scl;
        logic            eq;
        logic            ov;
    } t_side;

    // Sidecar that travels beside the dividers
    typedef struct packed {
        t_func           func;
        logic [2:0][31:0] vec;
        logic [31:0]     sout;
        logic            eq;
        logic            ov;
        logic            dz;
        logic            tiny;
    } t_fin;

    // Clamp a wide signed value into 32 bits
    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat s;
        s.ov  = 1'b0;
        s.val = v[31:0];
        if (v > 66'(MAX32)) begin
            s.ov  = 1'b1;
            s.val = MAX32;
        end else if (v < 66'(MIN32)) begin
            s.ov  = 1'b1;
            s.val = MIN32;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vector3_arithmetic_unit_top.sv
// Top level of the 3-vector ALU: stream ports, merge logic and output buffer.
// Depends on v3a_pkg, v3a_lane, v3a_sqrt and v3a_div.
//
// Usage: a slave stream carries one operation per transaction (operands in
// tdata, operation code in tuser); the master stream returns one result per
// transaction. The tiny-length threshold is written through i_cfg_wr_en /
// i_cfg_wr_data while no work is in flight.
// Pipeline: the path from acceptance to result valid is the same for every
// operation: three lane stages, one merge stage, 32 square root stages and
// 32 + FRAC_BITS divider stages.
// Throughput: one transaction per cycle while the skid register is empty, set
// by the fully pipelined square root and dividers.
// Reset clears all valid flags and sets the threshold to 1.
// Stall: a result waits in the output register while the pipe keeps moving;
// a second finished result goes to a skid register, and only then does the
// whole pipe hold and s_axis_tready drop until the master side drains.
`default_nettype none

module vector3_arithmetic_unit_top
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // ax, ay, az, bx, by, bz, scalar (32 bits each)
    input  wire logic [223:0] s_axis_tdata,
    // func
    input  wire logic [3:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // rx, ry, rz, scalar_out (32 each), equal, overflow, divide_by_zero, 5 pad
    output logic [135:0]      m_axis_tdata,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [15:0]  i_cfg_wr_data
);

    localparam int QW  = 32 + FRAC_BITS;
    localparam int LAT = 4 + SQRT_STAGES + QW;
    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    logic               w_en;
    t_func              w_func;
    logic signed [31:0] w_a [3];
    logic signed [31:0] w_b [3];
    logic signed [31:0] w_scl;
    logic [LAT-1:0]     r_vld;
    logic [15:0]        r_thr;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd1;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    // Unpack input transaction
    assign w_func = t_func'(s_axis_tuser);
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign w_a[i] = s_axis_tdata[32*i +: 32];
        assign w_b[i] = s_axis_tdata[96 + 32*i +: 32];
    end
    assign w_scl = s_axis_tdata[223:192];

    // Component lanes
    logic signed [63:0] w_prod [3];
    logic signed [31:0] w_res  [3];
    logic               w_lov  [3];
    logic [63:0]        w_sq   [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        v3a_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_func (w_func),
            .i_ai   (w_a[i]),
            .i_aj   (w_a[(i+1)%3]),
            .i_ak   (w_a[(i+2)%3]),
            .i_bi   (w_b[i]),
            .i_bj   (w_b[(i+1)%3]),
            .i_bk   (w_b[(i+2)%3]),
            .i_scl  (w_scl),
            .o_prod (w_prod[i]),
            .o_res  (w_res[i]),
            .o_ov   (w_lov[i]),
            .o_sq   (w_sq[i])
        );
    end

    // Merge stages beside the lanes
    t_func              r1_func, r2_func, r3_func;
    logic signed [31:0] r1_scl, r2_scl, r3_scl;
    logic               r1_eq, r2_eq, r3_eq;
    logic signed [65:0] r2_dsum;
    logic [31:0]        r3_dot;
    logic               r3_dov;
    t_sat               w_dsat;
    t_side              r4_side;
    logic [63:0]        r4_sumsq;

    assign w_dsat = sat32(r2_dsum >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_func  <= w_func;
            r1_scl   <= w_scl;
            r1_eq    <= (w_func == FN_EQ) && (w_a[0] == w_b[0]) &&
                        (w_a[1] == w_b[1]) && (w_a[2] == w_b[2]);
            r2_func  <= r1_func;
            r2_scl   <= r1_scl;
            r2_eq    <= r1_eq;
            r2_dsum  <= 66'(w_prod[0]) + 66'(w_prod[1]) + 66'(w_prod[2]) + HALF;
            r3_func  <= r2_func;
            r3_scl   <= r2_scl;
            r3_eq    <= r2_eq;
            r3_dot   <= w_dsat.val;
            r3_dov   <= w_dsat.ov && (r2_func == FN_SQLEN || r2_func == FN_DOT);
            r4_side.func <= r3_func;
            r4_side.vec  <= {w_res[2], w_res[1], w_res[0]};
            r4_side.sout <= r3_dot;
            r4_side.scl  <= r3_scl;
            r4_side.eq   <= r3_eq;
            r4_side.ov   <= w_lov[0] | w_lov[1] | w_lov[2] | r3_dov;
            r4_sumsq     <= w_sq[0] + w_sq[1] + w_sq[2];
        end
    end

    // Square root of the sum of squares
    logic [31:0] w_len;

    v3a_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_sumsq),
        .o_root (w_len)
    );

    t_side r_sd [SQRT_STAGES];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r4_side;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Divider setup after the root is known
    t_side         w_sd;
    t_fin          w_fin;
    logic          w_tiny, w_isdiv;
    logic [31:0]   w_lsat, w_smag;
    logic [QW-1:0] w_num [3];
    logic [31:0]   w_den;
    logic          w_dneg [3];

    assign w_sd   = r_sd[SQRT_STAGES-1];
    assign w_tiny = (w_len <= {16'd0, r_thr});
    assign w_isdiv = (w_sd.func == FN_DIV);
    assign w_lsat = w_len[31] ? MAX32 : w_len;
    assign w_smag = w_sd.scl[31] ? (32'd0 - w_sd.scl) : w_sd.scl;
    assign w_den  = w_isdiv ? w_smag : w_len;

    for (genvar i = 0; i < 3; i++) begin : g_dset
        logic [31:0] w_mag;
        assign w_mag     = w_sd.vec[i][31] ? (32'd0 - w_sd.vec[i]) : w_sd.vec[i];
        assign w_num[i]  = {w_mag, {FRAC_BITS{1'b0}}};
        assign w_dneg[i] = w_sd.vec[i][31] ^ (w_isdiv && w_sd.scl[31]);
    end

    always_comb begin
        w_fin.func = w_sd.func;
        w_fin.vec  = w_sd.vec;
        w_fin.eq   = w_sd.eq;
        w_fin.dz   = w_isdiv && (w_sd.scl == 32'd0);
        w_fin.tiny = w_tiny;
        w_fin.ov   = w_sd.ov;
        case (w_sd.func)
            FN_LEN: begin
                w_fin.sout = w_lsat;
                w_fin.ov   = w_sd.ov | w_len[31];
            end
            FN_NORM: begin
                w_fin.sout = w_tiny ? 32'd0 : w_lsat;
                w_fin.ov   = w_sd.ov | (w_len[31] && !w_tiny);
            end
            FN_SQLEN, FN_DOT: w_fin.sout = w_sd.sout;
            default:          w_fin.sout = 32'd0;
        endcase
    end

    // Dividers, one per lane
    logic [QW-1:0] w_quo  [3];
    logic          w_qneg [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3a_div #(
            .QW (QW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[i]),
            .i_den (w_den),
            .i_neg (w_dneg[i]),
            .o_quo (w_quo[i]),
            .o_neg (w_qneg[i])
        );
    end

    t_fin r_fd [QW];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fd[0] <= w_fin;
            for (int k = 1; k < QW; k++) begin
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // Final result select
    t_fin        w_f;
    logic [31:0] w_r   [3];
    logic        w_rov [3];

    assign w_f = r_fd[QW-1];

    for (genvar i = 0; i < 3; i++) begin : g_fsel
        logic [31:0] w_q;
        logic        w_qov;

        // Signed quotient clamped to 32 bits
        always_comb begin
            if (w_qneg[i]) begin
                w_qov = (w_quo[i] > QW'(33'h1_0000_0000 >> 1));
                w_q   = w_qov ? MIN32 : (32'd0 - w_quo[i][31:0]);
            end else begin
                w_qov = (w_quo[i] > QW'(MAX32));
                w_q   = w_qov ? MAX32 : w_quo[i][31:0];
            end
        end

        always_comb begin
            w_r[i]   = 32'd0;
            w_rov[i] = 1'b0;
            case (w_f.func)
                FN_ADD, FN_SUB, FN_SCALE, FN_NEG, FN_CPROD, FN_CROSS: begin
                    w_r[i] = w_f.vec[i];
                end
                FN_DIV: begin
                    if (w_f.dz) begin
                        if (w_f.vec[i][31]) begin
                            w_r[i] = MIN32;
                        end else if (w_f.vec[i] != 32'd0) begin
                            w_r[i] = MAX32;
                        end
                    end else begin
                        w_r[i]   = w_q;
                        w_rov[i] = w_qov;
                    end
                end
                FN_NORM, FN_UCROSS: begin
                    if (!w_f.tiny) begin
                        w_r[i]   = w_q;
                        w_rov[i] = w_qov;
                    end
                end
                default: ;
            endcase
        end
    end

    logic [135:0] w_pdata;
    assign w_pdata = {5'd0, w_f.dz, w_f.ov | w_rov[0] | w_rov[1] | w_rov[2],
                      w_f.eq, w_f.sout, w_r[2], w_r[1], w_r[0]};

    // Valid chain; the pipe holds only while the skid register is full
    logic         r_out_valid, r_skid_valid;
    logic [135:0] r_out_data, r_skid_data;

    assign w_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // Output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (r_vld[LAT-1]) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_data  <= w_pdata;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= w_pdata;
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: hw/rtl/v3a_lane.sv
// One component lane: products, rounding, saturation and squaring.
// Depends on v3a_pkg.
`default_nettype none

module v3a_lane
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  t_func                   i_func,
    input  wire logic signed [31:0] i_ai,
    input  wire logic signed [31:0] i_aj,
    input  wire logic signed [31:0] i_ak,
    input  wire logic signed [31:0] i_bi,
    input  wire logic signed [31:0] i_bj,
    input  wire logic signed [31:0] i_bk,
    input  wire logic signed [31:0] i_scl,
    output logic signed [63:0]      o_prod,   // first stage
    output logic signed [31:0]      o_res,    // third stage
    output logic                    o_ov,     // third stage
    output logic [63:0]             o_sq      // third stage
);

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    logic signed [31:0] w_m0a, w_m0b;
    logic signed [32:0] w_simp;
    logic signed [63:0] r_p0, r_p1;
    logic signed [32:0] r_simp;
    t_func              r_func1;
    logic signed [65:0] w_t, w_sh;
    t_sat               w_sat;
    logic signed [31:0] r_res, r_res3;
    logic               r_ov, r_ov3;
    logic [63:0]        r_sq;

    // Operand select and short arithmetic
    always_comb begin
        w_m0a  = i_ai;
        w_m0b  = i_bi;
        w_simp = 33'(i_ai);
        case (i_func)
            FN_SCALE:  w_m0b = i_scl;
            FN_SQLEN:  w_m0b = i_ai;
            FN_CROSS,
            FN_UCROSS: begin
                w_m0a = i_aj;
                w_m0b = i_bk;
            end
            default:   ;
        endcase
        case (i_func)
            FN_ADD:  w_simp = 33'(i_ai) + 33'(i_bi);
            FN_SUB:  w_simp = 33'(i_ai) - 33'(i_bi);
            FN_NEG:  w_simp = 33'sd0 - 33'(i_ai);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0    <= w_m0a * w_m0b;
            r_p1    <= i_ak * i_bj;
            r_simp  <= w_simp;
            r_func1 <= i_func;
        end
    end

    // Round to nearest, ties up, then clamp
    always_comb begin
        w_t = 66'(r_p0);
        if (r_func1 == FN_CROSS || r_func1 == FN_UCROSS) begin
            w_t = 66'(r_p0) - 66'(r_p1);
        end
        w_sh = (w_t + HALF) >>> FRAC_BITS;
        case (r_func1)
            FN_ADD, FN_SUB, FN_NEG:  w_sat = sat32(66'(r_simp));
            FN_SCALE, FN_CPROD,
            FN_CROSS, FN_UCROSS:     w_sat = sat32(w_sh);
            default: begin
                w_sat.ov  = 1'b0;
                w_sat.val = r_simp[31:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= w_sat.val;
            r_ov  <= w_sat.ov;
        end
    end

    // Square of the lane value for the length path
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= r_res * r_res;
            r_res3 <= r_res;
            r_ov3  <= r_ov;
        end
    end

    assign o_prod = r_p0;
    assign o_res  = r_res3;
    assign o_ov   = r_ov3;
    assign o_sq   = r_sq;

endmodule

`default_nettype wire

// File: hw/rtl/v3a_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on v3a_pkg.
`default_nettype none

module v3a_sqrt
    import v3a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_rad,
    output logic [31:0]      o_root
);

    logic [32:0] r_rem  [SQRT_STAGES];
    logic [31:0] r_root [SQRT_STAGES];
    logic [63:0] r_rad  [SQRT_STAGES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stg
        logic [32:0] w_pr;
        logic [31:0] w_proot;
        logic [63:0] w_prad;
        logic [34:0] w_rs, w_trial, w_df;
        logic        w_ge;

        if (g == 0) begin : g_first
            assign w_pr    = '0;
            assign w_proot = '0;
            assign w_prad  = i_rad;
        end else begin : g_next
            assign w_pr    = r_rem[g-1];
            assign w_proot = r_root[g-1];
            assign w_prad  = r_rad[g-1];
        end

        // Try appending a one to the partial root
        assign w_rs    = {w_pr, w_prad[63:62]};
        assign w_trial = {1'b0, w_proot, 2'b01};
        assign w_ge    = (w_rs >= w_trial);
        assign w_df    = w_rs - w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_ge ? w_df[32:0] : w_rs[32:0];
                r_root[g] <= {w_proot[30:0], w_ge};
                r_rad[g]  <= {w_prad[61:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/v3a_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on v3a_pkg.
`default_nettype none

module v3a_div
    import v3a_pkg::*;
#(
    parameter int QW = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [QW-1:0] i_num,
    input  wire logic [31:0]   i_den,
    input  wire logic          i_neg,
    output logic [QW-1:0]      o_quo,
    output logic               o_neg
);

    logic [31:0]   r_rem [QW];
    logic [QW-1:0] r_nq  [QW];
    logic [31:0]   r_den [QW];
    logic          r_neg [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stg
        logic [31:0]   w_pr, w_pd;
        logic [QW-1:0] w_pn;
        logic          w_pneg, w_ge;
        logic [32:0]   w_rs, w_df;

        if (g == 0) begin : g_first
            assign w_pr   = '0;
            assign w_pn   = i_num;
            assign w_pd   = i_den;
            assign w_pneg = i_neg;
        end else begin : g_next
            assign w_pr   = r_rem[g-1];
            assign w_pn   = r_nq[g-1];
            assign w_pd   = r_den[g-1];
            assign w_pneg = r_neg[g-1];
        end

        // Numerator bits shift out the top, quotient bits shift in below
        assign w_rs = {w_pr, w_pn[QW-1]};
        assign w_ge = (w_rs >= {1'b0, w_pd});
        assign w_df = w_rs - {1'b0, w_pd};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_ge ? w_df[31:0] : w_rs[31:0];
                r_nq[g]  <= {w_pn[QW-2:0], w_ge};
                r_den[g] <= w_pd;
                r_neg[g] <= w_pneg;
            end
        end
    end

    assign o_quo = r_nq[QW-1];
    assign o_neg = r_neg[QW-1];

endmodule

`default_nettype wire

// File: tb/vector3_arithmetic_unit_top_tb.sv
// Self-checking testbench for vector3_arithmetic_unit_top: streams directed and
// random vector operations, predicts each result and checks it field by field.
// Depends on v3a_pkg and the RTL of vector3_arithmetic_unit_top.
`default_nettype none

module vector3_arithmetic_unit_top_tb;
    import v3a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int PIPE_DEPTH = 84;

    typedef struct {
        logic [3:0]  func;
        logic [31:0] ax, ay, az, bx, by, bz, scl;
    } t_op;

    typedef struct {
        logic [31:0] rx, ry, rz, sout;
        bit          eq, ov, dz;
    } t_vres;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic [3:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         i_cfg_wr_en;
    logic [15:0]  i_cfg_wr_data;

    t_op         op_pending[$];
    t_vres       vres_expected[$];
    t_op         op_on_bus;
    logic [15:0] tiny_len;
    int          idle_pct;
    int          fail_cnt;

    vector3_arithmetic_unit_top #(.FRAC_BITS(FRAC)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- arithmetic helpers ----------------
    function automatic logic signed [127:0] wide(input logic [31:0] x);
        return {{96{x[31]}}, x};
    endfunction

    // Round to nearest, ties toward +infinity
    function automatic logic signed [127:0] qround(input logic signed [127:0] x);
        return (x + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [127:0] x, inout bit ov);
        if (x > 128'sh7FFF_FFFF) begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (x < -128'sh8000_0000) begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic [127:0] floor_root(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int i = 33; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Length of v, or zero at or below the threshold; unit vector into u when above the threshold
    function automatic logic [127:0] unit_vec(input logic [31:0] v[3], output logic [31:0] u[3],
                                              inout bit ov);
        logic [127:0] len;
        len = floor_root(wide(v[0]) * wide(v[0]) + wide(v[1]) * wide(v[1])
                         + wide(v[2]) * wide(v[2]));
        for (int i = 0; i < 3; i++) u[i] = '0;
        if (len <= {112'd0, tiny_len}) return '0;
        for (int i = 0; i < 3; i++)
            u[i] = clamp32((wide(v[i]) <<< FRAC) / $signed(len), ov);
        return len;
    endfunction

    function automatic void cross_vec(input logic [31:0] a[3], input logic [31:0] b[3],
                                      output logic [31:0] c[3], inout bit ov);
        c[0] = clamp32(qround(wide(a[1]) * wide(b[2]) - wide(a[2]) * wide(b[1])), ov);
        c[1] = clamp32(qround(wide(a[2]) * wide(b[0]) - wide(a[0]) * wide(b[2])), ov);
        c[2] = clamp32(qround(wide(a[0]) * wide(b[1]) - wide(a[1]) * wide(b[0])), ov);
    endfunction

    function automatic t_vres vector_alu(input t_op op);
        t_vres        res;
        logic [31:0]  a[3], b[3], r[3], c[3];
        logic [127:0] len;
        logic signed [127:0] s;
        bit           ov;
        a = '{op.ax, op.ay, op.az};
        b = '{op.bx, op.by, op.bz};
        r = '{32'd0, 32'd0, 32'd0};
        s = wide(op.scl);
        ov = 1'b0;
        res.sout = '0;
        res.eq = 1'b0;
        res.dz = 1'b0;
        case (op.func)
            FN_EQ: res.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            FN_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(wide(a[i]) + wide(b[i]), ov);
            FN_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(wide(a[i]) - wide(b[i]), ov);
            FN_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32(qround(wide(a[i]) * s), ov);
            FN_DIV: begin
                if (s == 0) begin
                    res.dz = 1'b1;
                    for (int i = 0; i < 3; i++)
                        r[i] = $signed(a[i]) > 0 ? 32'h7FFF_FFFF :
                               ($signed(a[i]) < 0 ? 32'h8000_0000 : 32'd0);
                end else begin
                    for (int i = 0; i < 3; i++)
                        r[i] = clamp32((wide(a[i]) <<< FRAC) / s, ov);
                end
            end
            FN_NEG: for (int i = 0; i < 3; i++) r[i] = clamp32(-wide(a[i]), ov);
            FN_CPROD: for (int i = 0; i < 3; i++) r[i] = clamp32(qround(wide(a[i]) * wide(b[i])), ov);
            FN_LEN: begin
                len = floor_root(wide(a[0]) * wide(a[0]) + wide(a[1]) * wide(a[1])
                                 + wide(a[2]) * wide(a[2]));
                res.sout = clamp32($signed(len), ov);
            end
            FN_SQLEN: res.sout = clamp32(qround(wide(a[0]) * wide(a[0])
                        + wide(a[1]) * wide(a[1]) + wide(a[2]) * wide(a[2])), ov);
            FN_DOT: res.sout = clamp32(qround(wide(a[0]) * wide(b[0])
                        + wide(a[1]) * wide(b[1]) + wide(a[2]) * wide(b[2])), ov);
            FN_NORM: begin
                len = unit_vec(a, r, ov);
                res.sout = clamp32($signed(len), ov);
            end
            FN_CROSS: cross_vec(a, b, r, ov);
            FN_UCROSS: begin
                cross_vec(a, b, c, ov);
                len = unit_vec(c, r, ov);
            end
            default: ;
        endcase
        res.rx = r[0];
        res.ry = r[1];
        res.rz = r[2];
        res.ov = ov;
        return res;
    endfunction

    // ---------------- sender side ----------------
    always @(posedge i_clk) begin
        t_op  nxt;
        logic vld;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            vld = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                vres_expected.push_back(vector_alu(op_on_bus));
                vld = 1'b0;
            end
            if (!vld && op_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
                nxt = op_pending.pop_front();
                op_on_bus <= nxt;
                s_axis_tdata <= {nxt.scl, nxt.bz, nxt.by, nxt.bx, nxt.az, nxt.ay, nxt.ax};
                s_axis_tuser <= nxt.func;
                vld = 1'b1;
            end
            s_axis_tvalid <= vld;
        end
    end

    // ---------------- receiver side and checks ----------------
    always @(posedge i_clk) begin
        t_vres exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (vres_expected.size() == 0) begin
                    $error("unexpected result transaction: %h", m_axis_tdata);
                    fail_cnt++;
                end else begin
                    exp_r = vres_expected.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.rx) begin
                        $error("rx: expected %h, got %h", exp_r.rx, m_axis_tdata[31:0]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[63:32] !== exp_r.ry) begin
                        $error("ry: expected %h, got %h", exp_r.ry, m_axis_tdata[63:32]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[95:64] !== exp_r.rz) begin
                        $error("rz: expected %h, got %h", exp_r.rz, m_axis_tdata[95:64]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[127:96] !== exp_r.sout) begin
                        $error("scalar_out: expected %h, got %h", exp_r.sout,
                               m_axis_tdata[127:96]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[128] !== exp_r.eq) begin
                        $error("equal: expected %b, got %b", exp_r.eq, m_axis_tdata[128]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[129] !== exp_r.ov) begin
                        $error("overflow: expected %b, got %b", exp_r.ov, m_axis_tdata[129]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[130] !== exp_r.dz) begin
                        $error("divide_by_zero: expected %b, got %b", exp_r.dz,
                               m_axis_tdata[130]);
                        fail_cnt++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_comp();
        logic [31:0] v;
        case ($urandom_range(7))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 4 << FRAC);
            3: v = $urandom_range(0, 300);
            4: v = 32'h7FFF_FFFF;
            5: v = 32'h8000_0000;
            6: v = 32'd0;
            default: v = $urandom_range(0, 1 << 20);
        endcase
        if (v != 32'h8000_0000 && v != 32'h7FFF_FFFF && $urandom_range(1)) v = -v;
        return v;
    endfunction

    task automatic add_op(input logic [3:0] f, input logic [31:0] ax, ay, az, bx, by, bz, scl);
        t_op op;
        op.func = f;
        op.ax = ax; op.ay = ay; op.az = az;
        op.bx = bx; op.by = by; op.bz = bz;
        op.scl = scl;
        op_pending.push_back(op);
    endtask

    task automatic add_random_ops(input int n);
        logic [3:0]  f;
        logic [31:0] ax, ay, az;
        for (int k = 0; k < n; k++) begin
            f = ($urandom_range(19) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
            ax = rand_comp();
            ay = rand_comp();
            az = rand_comp();
            // Equality hits need a copy of a
            if (f == FN_EQ && $urandom_range(1))
                add_op(f, ax, ay, az, ax, ay, ($urandom_range(1) ? az : rand_comp()), rand_comp());
            else
                add_op(f, ax, ay, az, rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    // Wait until the pipe is empty, then let it settle; sample between edges
    task automatic drain();
        while (op_pending.size() != 0 || s_axis_tvalid || vres_expected.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_DEPTH + 16) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        tiny_len      <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMIN = 32'h8000_0000;

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        tiny_len      = 16'd1;
        idle_pct      = 21;
        fail_cnt      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation and the special cases
        add_op(FN_EQ, ONE, 2, 3, ONE, 2, 3, 0);
        add_op(FN_EQ, ONE, 2, 3, ONE, 2, 4, 0);
        add_op(FN_ADD, PMAX, NMIN, 5, 1, 32'hFFFF_FFFF, 7, 0);
        add_op(FN_SUB, NMIN, PMAX, ONE, 1, 32'hFFFF_FFFF, ONE, 0);
        add_op(FN_SCALE, ONE, 32'h0000_8001, NMIN, 0, 0, 0, 32'h0000_8000);
        add_op(FN_SCALE, PMAX, 1, 32'hFFFF_FFFF, 0, 0, 0, PMAX);
        add_op(FN_DIV, 5, 32'hFFFF_FFFB, 0, 0, 0, 0, 0);
        add_op(FN_DIV, PMAX, NMIN, 3 << 16, 0, 0, 0, 32'hFFFF_0000);
        add_op(FN_DIV, ONE, 32'hFFFF_0000, 7, 0, 0, 0, 3);
        add_op(FN_NEG, NMIN, PMAX, 0, 0, 0, 0, 0);
        add_op(FN_CPROD, PMAX, NMIN, ONE, PMAX, PMAX, 32'hFFFF_8000, 0);
        add_op(FN_LEN, NMIN, NMIN, NMIN, 0, 0, 0, 0);
        add_op(FN_LEN, 3 << 16, 4 << 16, 0, 0, 0, 0, 0);
        add_op(FN_SQLEN, PMAX, 0, 0, 0, 0, 0, 0);
        add_op(FN_SQLEN, 2 << 16, 32'hFFFF_0000, 1, 0, 0, 0, 0);
        add_op(FN_DOT, ONE, 2 << 16, 3 << 16, 32'hFFFF_0000, ONE, NMIN, 0);
        add_op(FN_NORM, 1, 0, 0, 0, 0, 0, 0);
        add_op(FN_NORM, 2, 0, 0, 0, 0, 0, 0);
        add_op(FN_NORM, NMIN, NMIN, NMIN, 0, 0, 0, 0);
        add_op(FN_NORM, 3 << 16, 32'hFFFC_0000, 0, 0, 0, 0, 0);
        add_op(FN_CROSS, PMAX, NMIN, PMAX, NMIN, PMAX, NMIN, 0);
        add_op(FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
        add_op(FN_UCROSS, PMAX, 0, 0, 0, PMAX, 0, 0);
        add_op(FN_UCROSS, 1, 0, 0, 0, 1, 0, 0);
        add_op(4'd13, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
        add_op(4'd15, PMAX, NMIN, 1, 2, 3, 4, 5);
        add_random_ops(160);
        drain();

        // Threshold sweep, extremes included
        write_threshold(16'd0);
        add_random_ops(150);
        drain();
        write_threshold(16'hFFFF);
        add_random_ops(150);
        drain();
        write_threshold(16'($urandom));
        add_random_ops(150);
        drain();

        // Back-to-back stretch with neither side idling
        write_threshold(16'd200);
        idle_pct = 0;
        add_random_ops(150);
        drain();
        idle_pct = 21;
        write_threshold(16'd1);
        add_random_ops(140);
        drain();

        if (fail_cnt == 0)
            $display("vector3_arithmetic_unit_top test passed");
        else
            $display("vector3_arithmetic_unit_top test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("vector3_arithmetic_unit_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
